[hdl/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cell writer
// Grid geometry, field widths, item and byte codes, the cell layout, the
// controller/datapath interface structs and the tab stop table.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int unsigned COLUMNS  = 80;
  localparam int unsigned ROWS     = 25;
  localparam int unsigned TAB_STOP = 8;

  localparam int unsigned Cells = COLUMNS * ROWS;
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned TabW  = $clog2(COLUMNS + TAB_STOP);

  localparam int unsigned KindW     = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ColFieldW = 7;
  localparam int unsigned RowFieldW = 5;
  localparam int unsigned GlyphW    = 7;
  localparam int unsigned ColourW   = 32;
  localparam int unsigned AttrW     = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [KindW-1:0] KindWrite = KindW'(0);
  localparam logic [KindW-1:0] KindClear = KindW'(1);
  localparam logic [KindW-1:0] KindRead  = KindW'(2);

  localparam logic [CfgIndexW-1:0] CfgFg   = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] CfgBg   = CfgIndexW'(1);
  localparam logic [CfgIndexW-1:0] CfgAttr = CfgIndexW'(2);
  localparam logic [CfgIndexW-1:0] CfgWrap = CfgIndexW'(3);

  localparam logic [ByteW-1:0] CharBs     = ByteW'(8);
  localparam logic [ByteW-1:0] CharTab    = ByteW'(9);
  localparam logic [ByteW-1:0] CharLf     = ByteW'(10);
  localparam logic [ByteW-1:0] CharCr     = ByteW'(13);
  localparam logic [ByteW-1:0] PrintFirst = ByteW'(32);
  localparam logic [ByteW-1:0] PrintLast  = ByteW'(126);

  localparam logic [GlyphW-1:0]  BlankGlyph = GlyphW'(32);
  localparam logic [ColourW-1:0] ResetFg    = 32'hFFFF_FFFF;
  localparam logic [ColourW-1:0] ResetBg    = '0;
  localparam logic [AttrW-1:0]   ResetAttr  = '0;
  localparam logic               ResetWrap  = 1'b1;

  typedef struct packed {
    logic [GlyphW-1:0]  glyph;
    logic [ColourW-1:0] fg;
    logic [ColourW-1:0] bg;
    logic [AttrW-1:0]   attr;
  } cell_t;

  localparam int unsigned CellW = $bits(cell_t);

  typedef struct packed {
    logic capture;
    logic step;
    logic store;
    logic clear;
    logic rd_issue;
    logic rd_load;
    logic fill_init;
    logic fill_write;
    logic fill_blank;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_clear;
    logic is_read;
    logic is_print;
    logic print_row_valid;
    logic scroll_now;
    logic read_in_range;
    logic fill_last;
  } dp_status_t;

  typedef logic [TabW-1:0] tab_table_t [COLUMNS];

  // Next tab stop for every cursor column, built without division.
  function automatic tab_table_t build_tab_table();
    tab_table_t  t;
    int unsigned base;
    int unsigned phase;
    base  = 0;
    phase = 0;
    for (int unsigned c = 0; c < COLUMNS; c++) begin
      t[c]  = TabW'(base + TAB_STOP);
      phase = phase + 1;
      if (phase == TAB_STOP) begin
        phase = 0;
        base  = base + TAB_STOP;
      end
    end
    return t;
  endfunction

  localparam tab_table_t TabNext = build_tab_table();

endpackage

[hdl/text_console_cell_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_cell_writer_top: text console cell writer
// Character grid with per-cell colours and attribute, a cursor, scrolling
// through a rotating top-row pointer, clear and single-cell read.
//
// Channel   Direction  Handshake               Contents
// in        input      in_valid_i/in_ready_o   kind, char_byte, read_column, read_row
// out       output     out_valid_o/out_ready_i cursor, did_scroll, did_store, cell fields
// cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// Each word is stepped through decode and, for printable bytes and reads inside
// the grid, a cell store or cell read. A row fill through the single write
// port of the cell memory comes on top for a scroll, or for the first
// printable byte into a row blanked by reset or clear.
// Reset takes effect at once: rows blanked by reset or clear are marked in
// per-row valid bits and are filled when first written or when a scroll
// reuses them as the new bottom row.
// The next word is taken once the result has been taken.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tccw_pkg::KindW-1:0]          kind_i,
  input  logic [tccw_pkg::ByteW-1:0]          char_byte_i,
  input  logic [tccw_pkg::ColFieldW-1:0]      read_column_i,
  input  logic [tccw_pkg::RowFieldW-1:0]      read_row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tccw_pkg::ColFieldW-1:0]      cursor_column_o,
  output logic [tccw_pkg::RowFieldW-1:0]      cursor_row_o,
  output logic                                did_scroll_o,
  output logic                                did_store_o,
  output logic [tccw_pkg::GlyphW-1:0]         cell_glyph_o,
  output logic [tccw_pkg::ColourW-1:0]        cell_fg_o,
  output logic [tccw_pkg::ColourW-1:0]        cell_bg_o,
  output logic [tccw_pkg::AttrW-1:0]          cell_attr_o,
  input  logic                                cfg_we_i,
  input  logic [tccw_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [tccw_pkg::CfgDataW-1:0]       cfg_data_i
);

  tccw_pkg::ctrl_cmd_t  cmd;
  tccw_pkg::dp_status_t status;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tccw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (kind_i),
    .char_byte_i     (char_byte_i),
    .read_column_i   (read_column_i),
    .read_row_i      (read_row_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o),
    .did_scroll_o    (did_scroll_o),
    .did_store_o     (did_store_o),
    .cell_glyph_o    (cell_glyph_o),
    .cell_fg_o       (cell_fg_o),
    .cell_bg_o       (cell_bg_o),
    .cell_attr_o     (cell_attr_o)
  );

endmodule

[hdl/tccw_ram.sv]
// ----------------------------------------------------------------------------
// tccw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tccw_ctrl.sv]
// ----------------------------------------------------------------------------
// tccw_ctrl: sequencing controller
// Steps each accepted word through decode, cell read, row fill and store,
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  tccw_pkg::dp_status_t  status_i,
  output tccw_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] StIdle       = 3'd0;
  localparam logic [2:0] StDecode     = 3'd1;
  localparam logic [2:0] StRead       = 3'd2;
  localparam logic [2:0] StFillPre    = 3'd3;
  localparam logic [2:0] StStore      = 3'd4;
  localparam logic [2:0] StFillScroll = 3'd5;
  localparam logic [2:0] StOut        = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        if (status_i.is_write) begin
          if (status_i.is_print) begin
            if (status_i.print_row_valid) begin
              state_d = StStore;
            end else begin
              cmd_o.fill_init = 1'b1;
              state_d         = StFillPre;
            end
          end else begin
            cmd_o.step = 1'b1;
            state_d    = status_i.scroll_now ? StFillScroll : StOut;
          end
        end else if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = StOut;
        end else if (status_i.is_read && status_i.read_in_range) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = StRead;
        end else begin
          state_d = StOut;
        end
      end
      StRead: begin
        cmd_o.rd_load = 1'b1;
        state_d       = StOut;
      end
      StFillPre: begin
        cmd_o.fill_write = 1'b1;
        cmd_o.fill_blank = 1'b1;
        if (status_i.fill_last) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd_o.store = 1'b1;
        cmd_o.step  = 1'b1;
        state_d     = status_i.scroll_now ? StFillScroll : StOut;
      end
      StFillScroll: begin
        cmd_o.fill_write = 1'b1;
        if (status_i.fill_last) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

endmodule

[hdl/tccw_dp.sv]
// ----------------------------------------------------------------------------
// tccw_dp: console datapath
// Holds the configuration, cursor, rotating top-row pointer, per-row valid
// bits and the cell memory, and computes cursor moves and cell addresses.
// ----------------------------------------------------------------------------
module tccw_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tccw_pkg::ctrl_cmd_t                 cmd_i,
  output tccw_pkg::dp_status_t                status_o,
  input  logic [tccw_pkg::KindW-1:0]          kind_i,
  input  logic [tccw_pkg::ByteW-1:0]          char_byte_i,
  input  logic [tccw_pkg::ColFieldW-1:0]      read_column_i,
  input  logic [tccw_pkg::RowFieldW-1:0]      read_row_i,
  input  logic                                cfg_we_i,
  input  logic [tccw_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [tccw_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic [tccw_pkg::ColFieldW-1:0]      cursor_column_o,
  output logic [tccw_pkg::RowFieldW-1:0]      cursor_row_o,
  output logic                                did_scroll_o,
  output logic                                did_store_o,
  output logic [tccw_pkg::GlyphW-1:0]         cell_glyph_o,
  output logic [tccw_pkg::ColourW-1:0]        cell_fg_o,
  output logic [tccw_pkg::ColourW-1:0]        cell_bg_o,
  output logic [tccw_pkg::AttrW-1:0]          cell_attr_o
);

  // Logical row r lives in physical row (top + r) mod ROWS.
  function automatic logic [tccw_pkg::RowW-1:0] phys_row(
    input logic [tccw_pkg::RowW-1:0] top,
    input logic [tccw_pkg::RowW-1:0] r
  );
    logic [tccw_pkg::RowW:0] sum;
    sum = {1'b0, top} + {1'b0, r};
    if (sum >= (tccw_pkg::RowW + 1)'(tccw_pkg::ROWS)) begin
      sum = sum - (tccw_pkg::RowW + 1)'(tccw_pkg::ROWS);
    end
    return sum[tccw_pkg::RowW-1:0];
  endfunction

  function automatic logic [tccw_pkg::AddrW-1:0] cell_addr(
    input logic [tccw_pkg::RowW-1:0] r,
    input logic [tccw_pkg::ColW-1:0] c
  );
    logic [tccw_pkg::AddrW-1:0] base;
    base = tccw_pkg::AddrW'(r) * tccw_pkg::AddrW'(tccw_pkg::COLUMNS);
    return base + tccw_pkg::AddrW'(c);
  endfunction

  logic [tccw_pkg::KindW-1:0]      kind_q;
  logic [tccw_pkg::ByteW-1:0]      byte_q;
  logic [tccw_pkg::ColFieldW-1:0]  rcol_q;
  logic [tccw_pkg::RowFieldW-1:0]  rrow_q;

  logic [tccw_pkg::ColourW-1:0]    fg_q;
  logic [tccw_pkg::ColourW-1:0]    bg_q;
  logic [tccw_pkg::AttrW-1:0]      attr_q;
  logic                            wrap_q;
  logic [tccw_pkg::ColourW-1:0]    blank_fg_q;
  logic [tccw_pkg::ColourW-1:0]    blank_bg_q;
  logic [tccw_pkg::AttrW-1:0]      blank_attr_q;

  logic [tccw_pkg::ColW-1:0]       col_q;
  logic [tccw_pkg::ColW-1:0]       col_d;
  logic [tccw_pkg::RowW-1:0]       row_q;
  logic [tccw_pkg::RowW-1:0]       row_d;
  logic [tccw_pkg::RowW-1:0]       top_q;
  logic [tccw_pkg::ROWS-1:0]       row_valid_q;
  logic [tccw_pkg::RowW-1:0]       fill_row_q;
  logic [tccw_pkg::ColW-1:0]       fill_col_q;

  logic                            scroll_q;
  logic                            store_q;
  tccw_pkg::cell_t                 cell_q;

  logic [tccw_pkg::RowW-1:0]       cur_phys;
  logic [tccw_pkg::RowW-1:0]       rd_phys;
  logic [tccw_pkg::ColW-1:0]       rd_col;
  logic [tccw_pkg::TabW-1:0]       tab_next;
  logic                            tab_wrap;
  logic                            col_last;
  logic                            row_last;
  logic                            is_write;
  logic                            is_print;
  logic                            line_feed;
  logic                            rd_in_range;
  logic                            fill_last;

  logic                            ram_we;
  logic [tccw_pkg::AddrW-1:0]      ram_waddr;
  tccw_pkg::cell_t                 ram_wdata;
  logic [tccw_pkg::AddrW-1:0]      ram_raddr;
  tccw_pkg::cell_t                 ram_rdata;
  tccw_pkg::cell_t                 blank_cell;

  always_comb begin
    cur_phys    = phys_row(top_q, row_q);
    rd_col      = tccw_pkg::ColW'(rcol_q);
    rd_phys     = phys_row(top_q, tccw_pkg::RowW'(rrow_q));
    rd_in_range = (32'(rcol_q) < tccw_pkg::COLUMNS) && (32'(rrow_q) < tccw_pkg::ROWS);
    tab_next    = tccw_pkg::TabNext[col_q];
    tab_wrap    = (tab_next >= tccw_pkg::TabW'(tccw_pkg::COLUMNS));
    col_last    = (col_q == tccw_pkg::ColW'(tccw_pkg::COLUMNS - 1));
    row_last    = (row_q == tccw_pkg::RowW'(tccw_pkg::ROWS - 1));
    fill_last   = (fill_col_q == tccw_pkg::ColW'(tccw_pkg::COLUMNS - 1));
    is_write    = (kind_q == tccw_pkg::KindWrite);
    is_print    = is_write
                  && (byte_q inside {[tccw_pkg::PrintFirst:tccw_pkg::PrintLast]});
    line_feed   = is_write && ((byte_q == tccw_pkg::CharLf)
                  || ((byte_q == tccw_pkg::CharTab) && tab_wrap)
                  || (is_print && col_last && wrap_q));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (line_feed) begin
      col_d = '0;
      if (!row_last) begin
        row_d = row_q + 1'b1;
      end
    end else if (is_write) begin
      case (byte_q)
        tccw_pkg::CharCr: begin
          col_d = '0;
        end
        tccw_pkg::CharTab: begin
          col_d = tccw_pkg::ColW'(tab_next);
        end
        tccw_pkg::CharBs: begin
          if (col_q != '0) begin
            col_d = col_q - 1'b1;
          end
        end
        default: begin
          if (is_print && !col_last) begin
            col_d = col_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    status_o.is_write        = is_write;
    status_o.is_clear        = (kind_q == tccw_pkg::KindClear);
    status_o.is_read         = (kind_q == tccw_pkg::KindRead);
    status_o.is_print        = is_print;
    status_o.print_row_valid = row_valid_q[cur_phys];
    status_o.scroll_now      = line_feed && row_last;
    status_o.read_in_range   = rd_in_range;
    status_o.fill_last       = fill_last;
  end

  always_comb begin
    blank_cell.glyph = tccw_pkg::BlankGlyph;
    blank_cell.fg    = blank_fg_q;
    blank_cell.bg    = blank_bg_q;
    blank_cell.attr  = blank_attr_q;
    ram_we           = cmd_i.store || cmd_i.fill_write;
    ram_raddr        = cell_addr(rd_phys, rd_col);
    ram_wdata.fg     = fg_q;
    ram_wdata.bg     = bg_q;
    ram_wdata.attr   = attr_q;
    if (cmd_i.store) begin
      ram_waddr       = cell_addr(cur_phys, col_q);
      ram_wdata.glyph = tccw_pkg::GlyphW'(byte_q);
    end else begin
      ram_waddr       = cell_addr(fill_row_q, fill_col_q);
      ram_wdata.glyph = tccw_pkg::BlankGlyph;
      if (cmd_i.fill_blank) begin
        ram_wdata = blank_cell;
      end
    end
  end

  tccw_ram #(
    .Width (tccw_pkg::CellW),
    .Depth (tccw_pkg::Cells)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      byte_q   <= char_byte_i;
      rcol_q   <= read_column_i;
      rrow_q   <= read_row_i;
      scroll_q <= 1'b0;
      store_q  <= 1'b0;
      cell_q   <= '0;
    end
    if (cmd_i.step) begin
      scroll_q <= line_feed && row_last;
      store_q  <= is_print;
    end
    if (cmd_i.rd_load) begin
      cell_q <= row_valid_q[rd_phys] ? ram_rdata : blank_cell;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q         <= tccw_pkg::ResetFg;
      bg_q         <= tccw_pkg::ResetBg;
      attr_q       <= tccw_pkg::ResetAttr;
      wrap_q       <= tccw_pkg::ResetWrap;
      blank_fg_q   <= tccw_pkg::ResetFg;
      blank_bg_q   <= tccw_pkg::ResetBg;
      blank_attr_q <= tccw_pkg::ResetAttr;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tccw_pkg::CfgFg:   fg_q   <= cfg_data_i;
          tccw_pkg::CfgBg:   bg_q   <= cfg_data_i;
          tccw_pkg::CfgAttr: attr_q <= cfg_data_i[tccw_pkg::AttrW-1:0];
          tccw_pkg::CfgWrap: wrap_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (cmd_i.clear) begin
        blank_fg_q   <= fg_q;
        blank_bg_q   <= bg_q;
        blank_attr_q <= attr_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      row_valid_q <= '0;
      fill_row_q  <= '0;
      fill_col_q  <= '0;
    end else begin
      if (cmd_i.step) begin
        col_q <= col_d;
        row_q <= row_d;
        if (line_feed && row_last) begin
          top_q      <= phys_row(top_q, tccw_pkg::RowW'(1));
          fill_row_q <= top_q;
          fill_col_q <= '0;
        end
      end
      if (cmd_i.fill_init) begin
        fill_row_q <= cur_phys;
        fill_col_q <= '0;
      end
      if (cmd_i.fill_write) begin
        fill_col_q <= fill_col_q + 1'b1;
        if (fill_last) begin
          row_valid_q[fill_row_q] <= 1'b1;
        end
      end
      if (cmd_i.clear) begin
        row_valid_q <= '0;
      end
    end
  end

  assign cursor_column_o = tccw_pkg::ColFieldW'(col_q);
  assign cursor_row_o    = tccw_pkg::RowFieldW'(row_q);
  assign did_scroll_o    = scroll_q;
  assign did_store_o     = store_q;
  assign cell_glyph_o    = cell_q.glyph;
  assign cell_fg_o       = cell_q.fg;
  assign cell_bg_o       = cell_q.bg;
  assign cell_attr_o     = cell_q.attr;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text console cell writer
// Sends write, clear and read words over the input channel and checks every
// result word field by field against a cycle-free model of the cell grid and
// cursor. It covers control bytes, ignored bytes, wrap and clamp at the row
// end, scrolling, clear, reads inside and outside the grid, and several
// register settings under varying back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tccw_pkg::*;

  localparam logic [KindW-1:0] KindUnused = KindW'(3);
  localparam logic [ByteW-1:0] CharDel    = ByteW'(127);
  localparam int unsigned      StallLimit = 4000;
  localparam int unsigned      WordsPerSetting = 300;

  typedef struct {
    logic [ColFieldW-1:0] cursor_column;
    logic [RowFieldW-1:0] cursor_row;
    logic                 did_scroll;
    logic                 did_store;
    logic [GlyphW-1:0]    glyph;
    logic [ColourW-1:0]   fg;
    logic [ColourW-1:0]   bg;
    logic [AttrW-1:0]     attr;
  } console_status_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [KindW-1:0]     kind_i        = '0;
  logic [ByteW-1:0]     char_byte_i   = '0;
  logic [ColFieldW-1:0] read_column_i = '0;
  logic [RowFieldW-1:0] read_row_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [ColFieldW-1:0] cursor_column_o;
  logic [RowFieldW-1:0] cursor_row_o;
  logic                 did_scroll_o;
  logic                 did_store_o;
  logic [GlyphW-1:0]    cell_glyph_o;
  logic [ColourW-1:0]   cell_fg_o;
  logic [ColourW-1:0]   cell_bg_o;
  logic [AttrW-1:0]     cell_attr_o;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  text_console_cell_writer_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .char_byte_i,
    .read_column_i, .read_row_i, .out_valid_o, .out_ready_i, .cursor_column_o,
    .cursor_row_o, .did_scroll_o, .did_store_o, .cell_glyph_o, .cell_fg_o,
    .cell_bg_o, .cell_attr_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  logic [GlyphW-1:0]    glyph_grid [Cells];
  logic [ColourW-1:0]   fg_grid    [Cells];
  logic [ColourW-1:0]   bg_grid    [Cells];
  logic [AttrW-1:0]     attr_grid  [Cells];
  logic [ColFieldW-1:0] cursor_col;
  logic [RowFieldW-1:0] cursor_line;
  logic [ColourW-1:0]   fg_colour;
  logic [ColourW-1:0]   bg_colour;
  logic [AttrW-1:0]     attr_byte;
  logic                 wrap_on;

  console_status_t expected_status [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned failures      = 0;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned scrolls_seen  = 0;
  int unsigned stores_seen   = 0;
  int unsigned clears_sent   = 0;
  int unsigned stall_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void blank_cell(int unsigned idx);
    glyph_grid[idx] = BlankGlyph;
    fg_grid[idx]    = fg_colour;
    bg_grid[idx]    = bg_colour;
    attr_grid[idx]  = attr_byte;
  endfunction

  function automatic logic advance_line();
    cursor_col = '0;
    if (cursor_line + 1 < ROWS) begin
      cursor_line = cursor_line + 1'b1;
      return 1'b0;
    end
    for (int unsigned i = 0; i + COLUMNS < Cells; i++) begin
      glyph_grid[i] = glyph_grid[i + COLUMNS];
      fg_grid[i]    = fg_grid[i + COLUMNS];
      bg_grid[i]    = bg_grid[i + COLUMNS];
      attr_grid[i]  = attr_grid[i + COLUMNS];
    end
    for (int unsigned i = Cells - COLUMNS; i < Cells; i++) blank_cell(i);
    return 1'b1;
  endfunction

  function automatic console_status_t predict_status(
    logic [KindW-1:0] word_kind, logic [ByteW-1:0] word_byte,
    logic [ColFieldW-1:0] word_col, logic [RowFieldW-1:0] word_row);
    console_status_t st;
    int unsigned     idx;
    int unsigned     next_stop;
    st = '{default: '0};
    if (word_kind == KindWrite) begin
      if (word_byte == CharLf) begin
        st.did_scroll = advance_line();
      end else if (word_byte == CharCr) begin
        cursor_col = '0;
      end else if (word_byte == CharTab) begin
        next_stop = (cursor_col / TAB_STOP + 1) * TAB_STOP;
        if (next_stop >= COLUMNS) st.did_scroll = advance_line();
        else cursor_col = ColFieldW'(next_stop);
      end else if (word_byte == CharBs) begin
        if (cursor_col > 0) cursor_col = cursor_col - 1'b1;
      end else if (word_byte >= PrintFirst && word_byte <= PrintLast) begin
        idx = cursor_line * COLUMNS + cursor_col;
        glyph_grid[idx] = GlyphW'(word_byte);
        fg_grid[idx]    = fg_colour;
        bg_grid[idx]    = bg_colour;
        attr_grid[idx]  = attr_byte;
        st.did_store    = 1'b1;
        if (cursor_col + 1 >= COLUMNS) begin
          if (wrap_on) st.did_scroll = advance_line();
          else cursor_col = ColFieldW'(COLUMNS - 1);
        end else begin
          cursor_col = cursor_col + 1'b1;
        end
      end
    end else if (word_kind == KindClear) begin
      for (int unsigned i = 0; i < Cells; i++) blank_cell(i);
    end else if (word_kind == KindRead) begin
      if (word_col < COLUMNS && word_row < ROWS) begin
        idx      = word_row * COLUMNS + word_col;
        st.glyph = glyph_grid[idx];
        st.fg    = fg_grid[idx];
        st.bg    = bg_grid[idx];
        st.attr  = attr_grid[idx];
      end
    end
    st.cursor_column = cursor_col;
    st.cursor_row    = cursor_line;
    return st;
  endfunction

  task automatic send_word(input logic [KindW-1:0] word_kind,
                           input logic [ByteW-1:0] word_byte,
                           input logic [ColFieldW-1:0] word_col,
                           input logic [RowFieldW-1:0] word_row);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= word_kind;
    char_byte_i   <= word_byte;
    read_column_i <= word_col;
    read_row_i    <= word_row;
    do @(posedge clk_i); while (!in_ready_o);
    expected_status.push_back(predict_status(word_kind, word_byte, word_col, word_row));
    words_sent++;
    if (word_kind == KindClear) clears_sent++;
  endtask

  task automatic put_byte(input logic [ByteW-1:0] b);
    send_word(KindWrite, b, ColFieldW'($urandom), RowFieldW'($urandom));
  endtask

  task automatic read_cell(input int unsigned col, input int unsigned row);
    send_word(KindRead, ByteW'($urandom), ColFieldW'(col), RowFieldW'(row));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [ColourW-1:0] fg, input logic [ColourW-1:0] bg,
                                input logic [AttrW-1:0] attr, input logic wrap);
    logic [CfgIndexW-1:0] idx  [4];
    logic [CfgDataW-1:0]  data [4];
    idx  = '{CfgFg, CfgBg, CfgAttr, CfgWrap};
    data = '{CfgDataW'(fg), CfgDataW'(bg), CfgDataW'(attr), CfgDataW'(wrap)};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    fg_colour = fg;
    bg_colour = bg;
    attr_byte = attr;
    wrap_on   = wrap;
  endtask

  task automatic test_reset_grid();
    read_cell(0, 0);
    read_cell(COLUMNS - 1, ROWS - 1);
    read_cell(COLUMNS, 0);
    read_cell(0, ROWS);
    read_cell(127, 31);
  endtask

  task automatic test_control_bytes();
    put_byte("A");
    put_byte(CharBs);
    put_byte(CharBs);
    put_byte(PrintLast);
    put_byte(PrintFirst);
    put_byte(CharCr);
    put_byte(CharTab);
    put_byte(CharTab);
    put_byte(CharBs);
    put_byte(CharLf);
    put_byte(CharDel);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h1F);
    send_word(KindUnused, 8'hFF, 7'h7F, 5'h1F);
    read_cell(0, 0);
    read_cell(1, 0);
  endtask

  task automatic test_clear_and_settings();
    int unsigned col;
    int unsigned row;
    send_word(KindClear, 8'hFF, 7'h7F, 5'h1F);
    read_cell(0, 0);
    apply_settings(32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_word(KindClear, 8'h00, 7'h00, 5'h00);
    read_cell(5, 10);
    col = cursor_col;
    row = cursor_line;
    put_byte("Z");
    read_cell(col, row);
  endtask

  // Lines of printable text with random length, mixed with reads, noise and
  // line control, so that wrap, clamp and scrolling are reached often.
  task automatic run_traffic(input int unsigned n_words);
    int unsigned done_words;
    int unsigned len;
    int unsigned pick;
    logic [ByteW-1:0] b;
    done_words = 0;
    while (done_words < n_words) begin
      len = ($urandom_range(9) < 7) ? $urandom_range(20) : $urandom_range(100);
      for (int unsigned i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          read_cell($urandom_range(COLUMNS - 1),
                    $urandom_range(1) ? cursor_line : $urandom_range(ROWS - 1));
          done_words++;
        end else if (pick < 14) begin
          read_cell($urandom_range(127), $urandom_range(31));
          done_words++;
        end else if (pick < 17) begin
          b = ByteW'($urandom);
          if (b >= PrintFirst || b == CharLf || b == CharCr || b == CharTab || b == CharBs)
            b = b | 8'h80;
          put_byte(b);
        end else if (pick < 18) begin
          send_word(KindUnused, ByteW'($urandom), ColFieldW'($urandom), RowFieldW'($urandom));
        end else begin
          put_byte(ByteW'($urandom_range(PrintFirst, PrintLast)));
          done_words++;
        end
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        put_byte(CharLf);
      end else if (pick < 65) begin
        put_byte(CharCr);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 10)) put_byte(CharTab);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) put_byte(CharBs);
      end else if (pick < 89) begin
        send_word(KindClear, ByteW'($urandom), ColFieldW'($urandom), RowFieldW'($urandom));
      end
      done_words++;
    end
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 33;
    recv_idle_pct = 83;
    apply_settings($urandom, $urandom, AttrW'($urandom), 1'b1);
    run_traffic(WordsPerSetting);
    apply_settings(32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    run_traffic(WordsPerSetting);
  endtask

  task automatic test_slow_sender();
    send_idle_pct = 83;
    recv_idle_pct = 33;
    apply_settings(32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1'b1);
    run_traffic(WordsPerSetting);
    apply_settings($urandom, $urandom, AttrW'($urandom), 1'b0);
    run_traffic(WordsPerSetting);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings($urandom, $urandom, AttrW'($urandom), 1'b1);
    run_traffic(WordsPerSetting);
    apply_settings(ResetFg, ResetBg, ResetAttr, ResetWrap);
    run_traffic(WordsPerSetting);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    console_status_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_status.size() == 0) begin
        $error("result word with no word outstanding");
        failures++;
      end else begin
        e = expected_status.pop_front();
        compare_field("cursor_column", 32'(e.cursor_column), 32'(cursor_column_o));
        compare_field("cursor_row", 32'(e.cursor_row), 32'(cursor_row_o));
        compare_field("did_scroll", 32'(e.did_scroll), 32'(did_scroll_o));
        compare_field("did_store", 32'(e.did_store), 32'(did_store_o));
        compare_field("cell_glyph", 32'(e.glyph), 32'(cell_glyph_o));
        compare_field("cell_fg", e.fg, cell_fg_o);
        compare_field("cell_bg", e.bg, cell_bg_o);
        compare_field("cell_attr", 32'(e.attr), 32'(cell_attr_o));
        results_seen++;
        scrolls_seen += e.did_scroll;
        stores_seen  += e.did_store;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    fg_colour   = ResetFg;
    bg_colour   = ResetBg;
    attr_byte   = ResetAttr;
    wrap_on     = ResetWrap;
    cursor_col  = '0;
    cursor_line = '0;
    for (int unsigned i = 0; i < Cells; i++) blank_cell(i);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 33;
    recv_idle_pct = 83;
    test_reset_grid();
    test_control_bytes();
    test_clear_and_settings();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    settle();
    repeat (2 * COLUMNS + 8) @(posedge clk_i);
    $display("Sent %0d words (%0d clears) under three back-pressure patterns.",
             words_sent, clears_sent);
    $display("Checked %0d results: %0d scrolls, %0d stored bytes, %0d mismatches.",
             results_seen, scrolls_seen, stores_seen, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
